FILE: hdl/cmfw_pkg.sv
// Shared types, codes and the field format table for the card message field walker.
// No dependencies; imported by cmfw_next_field and card_message_field_walker.
package cmfw_pkg;

  // Message state sizing
  localparam int MessageBytes = 2048;
  localparam int PosW         = 11;
  localparam int LenW         = 10;
  localparam int NumFields    = 128;
  localparam logic [PosW-1:0] PosMax  = 11'd2047;
  localparam logic [LenW-1:0] LenMax  = 10'd999;

  // Walk phases
  typedef enum logic [2:0] {
    PhId,
    PhPbmp,
    PhSeek,
    PhPrefix,
    PhData,
    PhPast,
    PhError
  } phase_t;

  // Region codes reported with every byte
  localparam logic [2:0] RegId     = 3'd0;
  localparam logic [2:0] RegPbmp   = 3'd1;
  localparam logic [2:0] RegPrefix = 3'd2;
  localparam logic [2:0] RegData   = 3'd3;
  localparam logic [2:0] RegPast   = 3'd4;
  localparam logic [2:0] RegError  = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CfgBcdLengths = 2'd0;
  localparam logic [1:0] CfgTarget     = 2'd1;
  localparam logic [1:0] CfgMaxField   = 2'd2;
  localparam logic [1:0] CfgExtraClear = 2'd3;

  // Variable-length kind codes in the format table; below 0x80 is a fixed byte count
  localparam logic [7:0] KindVarFlag = 8'h80;
  localparam logic [7:0] KindLln     = 8'h81;
  localparam logic [7:0] KindLlln    = 8'h82;
  localparam logic [7:0] KindLla     = 8'h83;
  localparam logic [7:0] KindLll     = 8'h84;

  // Fields that always stay in clear (subject to max_field)
  localparam logic [7:0] ClrRespCode = 8'd39;
  localparam logic [7:0] ClrTermId   = 8'd41;
  localparam logic [7:0] ClrMerchId  = 8'd42;
  localparam logic [7:0] ClrSecCtl   = 8'd53;

  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiNine = 8'h39;

  localparam logic [7:0] L1 = KindLln;
  localparam logic [7:0] L3 = KindLlln;
  localparam logic [7:0] LA = KindLla;
  localparam logic [7:0] LL = KindLll;

  localparam logic [7:0] FMT_ROM [0:NumFields] = '{
    8'd0,
    8'd8,  L1,    8'd3,  8'd6,  8'd6,  8'd6,  8'd5,  8'd4,
    8'd4,  8'd4,  8'd3,  8'd3,  8'd2,  8'd2,  8'd2,  8'd2,
    8'd2,  8'd2,  8'd2,  8'd2,  8'd2,  8'd2,  8'd2,  8'd2,
    8'd1,  8'd1,  8'd1,  8'd5,  8'd5,  8'd5,  8'd5,  L1,
    L1,    LA,    L1,    L3,    8'd12, 8'd6,  8'd2,  8'd3,
    8'd8,  8'd15, 8'd40, LA,    LA,    LL,    LL,    LL,
    8'd2,  8'd2,  8'd2,  8'd8,  8'd8,  LL,    LL,    LL,
    8'd6,  8'd6,  8'd6,  LL,    LL,    LL,    LL,    8'd8,
    8'd8,  8'd1,  8'd1,  8'd2,  8'd2,  8'd2,  8'd2,  8'd2,
    8'd3,  8'd5,  8'd5,  8'd5,  8'd5,  8'd5,  8'd5,  8'd5,
    8'd5,  8'd6,  8'd6,  8'd6,  8'd6,  8'd8,  8'd8,  8'd8,
    8'd8,  8'd21, 8'd1,  8'd2,  8'd5,  8'd7,  8'd42, 8'd8,
    8'd9,  LA,    L1,    L1,    LA,    LA,    LA,    LL,
    LL,    LL,    LL,    LL,    LL,    LL,    LL,    LL,
    LL,    LL,    LL,    LL,    8'd2,  8'd5,  8'd8,  LL,
    LL,    LL,    LL,    LL,    LL,    LL,    LL,    8'd8
  };

  function automatic logic [7:0] fmt_code(input logic [7:0] f);
    logic [7:0] code;
    code = 8'd0;
    if (f <= 8'(NumFields)) begin
      code = FMT_ROM[f];
    end
    return code;
  endfunction

  // Result of the next-present-field search
  typedef struct packed {
    logic       found;
    logic [7:0] field;
  } next_field_t;

endpackage

FILE: hdl/cmfw_next_field.sv
// Priority search for the lowest present field above the current one.
// Depends on cmfw_pkg (next_field_t).
module cmfw_next_field (
  input  logic [127:0]              bitmap,
  input  logic [7:0]                after,
  output cmfw_pkg::next_field_t     nf
);
  import cmfw_pkg::*;

  logic [128:0] low_mask;
  logic [127:0] keep;
  logic [127:0] lowest;

  // field f sits at bit f-1, so fields above 'after' are bits 'after' and up
  assign low_mask = (129'd1 << after) - 129'd1;
  assign keep     = bitmap & ~low_mask[127:0];
  assign lowest   = keep & (~keep + 128'd1);

  always_comb begin
    nf.found = |keep;
    nf.field = 8'd0;
    for (int i = 0; i < NumFields; i++) begin
      if (lowest[i]) begin
        nf.field = nf.field | 8'(i + 1);
      end
    end
  end

endmodule

FILE: hdl/card_message_field_walker.sv
// Top level of the card message field walker: tags each message byte with its field.
// Depends on cmfw_pkg and cmfw_next_field.
//
// Usage:
//   Slave stream s_*: one message byte per beat, s_tlast on the final byte.
//   Master stream m_*: one tagged beat per input beat, same order; m_tdata
//   carries the byte, its field number and its offset, m_tuser carries the
//   region and the clear / selected flags, m_tlast echoes s_tlast.
//   Config port: cfg_we writes cfg_data into register cfg_index
//   (0 bcd_lengths, 1 target_field, 2 max_field, 3 extra_clear_field).
//   Write registers only while no beat is in flight.
// Throughput:
//   Each byte is processed in the cycle it is accepted and its result sits in
//   the output register the next cycle; 1 byte per cycle while m_tready is high.
//   The per-byte path is the next-present-field priority encode over the
//   128-bit presence bitmap feeding the length-digit accumulate.
// Reset: rst (synchronous) empties the output register, returns the walk to
//   the message-id phase and loads the register defaults.
// Stall: with m_tready low a held result blocks s_tready; s_tready follows
//   m_tready combinationally, so no beat is lost or repeated.
module card_message_field_walker (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] msg_byte
  input  logic        s_tlast,   // end_of_message
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] out_byte, [15:8] field_number, [25:16] offset_in_field
  output logic [4:0]  m_tuser,   // [2:0] region, [3] is_clear, [4] is_selected
  output logic        m_tlast,   // last
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import cmfw_pkg::*;

  // configuration registers
  logic       bcd_lengths;
  logic [7:0] target_field;
  logic [7:0] max_field;
  logic [7:0] extra_clear_field;

  // message walk state
  logic [PosW-1:0] byte_position;
  logic [127:0]    presence_bitmap;
  logic [7:0]      current_field;
  logic [LenW-1:0] bytes_left;
  logic [LenW-1:0] length_accumulator;
  phase_t          parse_phase;
  logic [1:0]      prefix_bytes_left;

  logic [PosW-1:0] byte_position_next;
  logic [127:0]    presence_bitmap_next;
  logic [7:0]      current_field_next;
  logic [LenW-1:0] bytes_left_next;
  logic [LenW-1:0] length_accumulator_next;
  phase_t          parse_phase_next;
  logic [1:0]      prefix_bytes_left_next;

  // per-byte tags
  logic [2:0]      tag_region;
  logic [7:0]      tag_field;
  logic [LenW-1:0] tag_offset;
  logic            tag_clear;
  logic            tag_sel;

  logic        in_beat;
  next_field_t nf;

  assign s_tready = !m_tvalid || m_tready;
  assign in_beat  = s_tvalid && s_tready;

  cmfw_next_field u_next_field (
    .bitmap (presence_bitmap),
    .after  (current_field),
    .nf     (nf)
  );

  always_comb begin
    logic [7:0]  b;
    logic [7:0]  code;
    logic [7:0]  kind;
    logic        ascii;
    logic        bad;
    logic [3:0]  hi;
    logic [3:0]  lo;
    logic [16:0] acc_w;
    logic [LenW-1:0] acc_sat;
    logic [LenW-1:0] len;
    logic [2:0]  k;
    logic [3:0]  slot;
    logic        load;
    logic [7:0]  rev;
    logic [LenW-1:0] doff;

    b     = s_tdata;
    code  = 8'd0;
    kind  = 8'd0;
    ascii = 1'b0;
    bad   = 1'b0;
    hi    = 4'd0;
    lo    = 4'd0;
    acc_w = 17'd0;
    acc_sat = '0;
    len   = '0;
    k     = 3'd0;
    slot  = 4'd0;
    load  = 1'b0;
    doff  = '0;
    for (int j = 0; j < 8; j++) begin
      rev[j] = b[7-j];
    end

    presence_bitmap_next    = presence_bitmap;
    current_field_next      = current_field;
    bytes_left_next         = bytes_left;
    length_accumulator_next = length_accumulator;
    parse_phase_next        = parse_phase;
    prefix_bytes_left_next  = prefix_bytes_left;

    tag_region = RegPast;
    tag_field  = 8'd0;
    tag_offset = '0;
    tag_clear  = 1'b0;
    tag_sel    = 1'b0;

    // buffer overflow would end the walk, but byte_position saturates below MessageBytes
    if (int'(byte_position) >= MessageBytes && parse_phase != PhError) begin
      parse_phase_next = PhPast;
    end

    // seek the next present field and load its format
    if (parse_phase_next == PhSeek) begin
      parse_phase_next = PhPast;
      if (nf.found) begin
        code                    = fmt_code(nf.field);
        current_field_next      = nf.field;
        length_accumulator_next = '0;
        bytes_left_next         = '0;
        if (code < KindVarFlag) begin
          length_accumulator_next = LenW'(code);
          bytes_left_next         = LenW'(code);
          parse_phase_next        = PhData;
        end else begin
          if (code == KindLln) begin
            prefix_bytes_left_next = 2'd1;
          end else if (code == KindLll && !bcd_lengths) begin
            prefix_bytes_left_next = 2'd3;
          end else begin
            prefix_bytes_left_next = 2'd2;
          end
          parse_phase_next = PhPrefix;
        end
      end
    end

    case (parse_phase_next)
      PhId: begin
        tag_region = RegId;
        tag_offset = byte_position[LenW-1:0];
        tag_clear  = 1'b1;
        tag_sel    = (target_field == 8'd0);
        if (byte_position != '0) begin
          parse_phase_next = PhPbmp;
        end
      end
      PhPbmp: begin
        k          = byte_position[2:0] - 3'd2;
        tag_region = RegPbmp;
        tag_offset = LenW'(k);
        tag_clear  = 1'b1;
        load       = 1'b1;
        slot       = {1'b0, k};
        if (byte_position >= PosW'(9)) begin
          parse_phase_next   = PhSeek;
          current_field_next = 8'd0;
        end
      end
      PhPrefix: begin
        kind      = fmt_code(current_field_next);
        ascii     = (kind == KindLla) || (kind == KindLll && !bcd_lengths);
        tag_field = current_field_next;
        if (ascii) begin
          if (b < AsciiZero || b > AsciiNine) begin
            bad = 1'b1;
          end else begin
            acc_w = 17'(length_accumulator_next) * 17'd10 + 17'(b[3:0]);
          end
        end else begin
          // nibbles above 9 count as zero; first byte of a 2-byte length is a pad nibble
          hi = (b[7:4] > 4'd9) ? 4'd0 : b[7:4];
          lo = (b[3:0] > 4'd9) ? 4'd0 : b[3:0];
          if (prefix_bytes_left_next == 2'd2) begin
            acc_w = 17'(length_accumulator_next) * 17'd100 + 17'(lo);
          end else begin
            acc_w = 17'(length_accumulator_next) * 17'd100 + 17'(hi) * 17'd10 + 17'(lo);
          end
        end
        acc_sat = (acc_w > 17'(LenMax)) ? LenMax : acc_w[LenW-1:0];
        if (bad) begin
          tag_region       = RegError;
          parse_phase_next = PhError;
        end else begin
          tag_region = RegPrefix;
          tag_offset = bytes_left_next;
          tag_clear  = (current_field_next >= 8'd1) && (current_field_next <= max_field);
          bytes_left_next         = bytes_left_next + LenW'(1);
          length_accumulator_next = acc_sat;
          if (prefix_bytes_left_next <= 2'd1) begin
            len = acc_sat;
            if (kind == KindLln || kind == KindLlln) begin
              // numeric data packs two digits per byte
              len = LenW'((11'(acc_sat) + 11'd1) >> 1);
            end
            prefix_bytes_left_next  = 2'd0;
            length_accumulator_next = len;
            bytes_left_next         = len;
            parse_phase_next        = (len == '0) ? PhSeek : PhData;
          end else begin
            prefix_bytes_left_next = prefix_bytes_left_next - 2'd1;
          end
        end
      end
      PhData: begin
        doff       = length_accumulator_next - bytes_left_next;
        tag_region = RegData;
        tag_field  = current_field_next;
        tag_offset = doff;
        tag_clear  = (current_field_next >= 8'd1) && (current_field_next <= max_field) &&
                     (current_field_next == ClrRespCode || current_field_next == ClrTermId ||
                      current_field_next == ClrMerchId  || current_field_next == ClrSecCtl ||
                      (extra_clear_field != 8'd0 && current_field_next == extra_clear_field));
        tag_sel    = (target_field != 8'd0) && (target_field == current_field_next);
        // field 1 is the secondary bitmap: fields 65..128
        if (current_field_next == 8'd1) begin
          load = 1'b1;
          slot = {1'b1, doff[2:0]};
        end
        if (bytes_left_next <= LenW'(1)) begin
          bytes_left_next  = '0;
          parse_phase_next = PhSeek;
        end else begin
          bytes_left_next = bytes_left_next - LenW'(1);
        end
      end
      PhError: begin
        tag_region = RegError;
        tag_field  = current_field_next;
      end
      default: begin
        tag_region = RegPast;
      end
    endcase

    if (load) begin
      presence_bitmap_next[{slot, 3'b000} +: 8] = presence_bitmap[{slot, 3'b000} +: 8] | rev;
    end

    byte_position_next = (byte_position < PosMax) ? byte_position + PosW'(1) : byte_position;

    // end of message: back to a fresh walk
    if (s_tlast) begin
      byte_position_next      = '0;
      presence_bitmap_next    = '0;
      current_field_next      = 8'd0;
      bytes_left_next         = '0;
      length_accumulator_next = '0;
      parse_phase_next        = PhId;
      prefix_bytes_left_next  = 2'd0;
    end
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid           <= 1'b0;
      bcd_lengths        <= 1'b1;
      target_field       <= 8'd0;
      max_field          <= 8'd53;
      extra_clear_field  <= 8'd0;
      byte_position      <= '0;
      presence_bitmap    <= '0;
      current_field      <= 8'd0;
      bytes_left         <= '0;
      length_accumulator <= '0;
      parse_phase        <= PhId;
      prefix_bytes_left  <= 2'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgBcdLengths: bcd_lengths       <= cfg_data[0];
          CfgTarget:     target_field      <= cfg_data;
          CfgMaxField:   max_field         <= cfg_data;
          CfgExtraClear: extra_clear_field <= cfg_data;
          default:       bcd_lengths       <= bcd_lengths;
        endcase
      end
      if (in_beat) begin
        m_tvalid           <= 1'b1;
        byte_position      <= byte_position_next;
        presence_bitmap    <= presence_bitmap_next;
        current_field      <= current_field_next;
        bytes_left         <= bytes_left_next;
        length_accumulator <= length_accumulator_next;
        parse_phase        <= parse_phase_next;
        prefix_bytes_left  <= prefix_bytes_left_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (in_beat) begin
      m_tdata <= {6'd0, tag_offset, tag_field, s_tdata};
      m_tuser <= {tag_sel, tag_clear, tag_region};
      m_tlast <= s_tlast;
    end
  end

endmodule

FILE: tb/cmfw_tag_checker.sv
// Scoreboard for the card message field walker: mirrors register writes, predicts the tag of
// every accepted message byte and compares it with the tagged output beats.
// Depends on cmfw_pkg for the phase enum, region codes, register indexes and kind codes.
module cmfw_tag_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [4:0]  m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          errors,
  output int          pending,
  output int          checked,
  output logic [5:0]  regions_seen
);
  import cmfw_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] region;
    logic [7:0] field;
    logic [9:0] offset;
    logic       clr;
    logic       sel;
    logic       eom;
  } beat_tag_t;

  // Field layout: byte count of a fixed field, or a variable-length kind code.
  localparam logic [7:0] VN  = KindLln;
  localparam logic [7:0] VN3 = KindLlln;
  localparam logic [7:0] VA  = KindLla;
  localparam logic [7:0] VL  = KindLll;
  localparam logic [7:0] FORMAT_TABLE [0:128] = '{
    8'd0,
    8'd8,  VN,    8'd3,  8'd6,  8'd6,  8'd6,  8'd5,  8'd4,
    8'd4,  8'd4,  8'd3,  8'd3,  8'd2,  8'd2,  8'd2,  8'd2,
    8'd2,  8'd2,  8'd2,  8'd2,  8'd2,  8'd2,  8'd2,  8'd2,
    8'd1,  8'd1,  8'd1,  8'd5,  8'd5,  8'd5,  8'd5,  VN,
    VN,    VA,    VN,    VN3,   8'd12, 8'd6,  8'd2,  8'd3,
    8'd8,  8'd15, 8'd40, VA,    VA,    VL,    VL,    VL,
    8'd2,  8'd2,  8'd2,  8'd8,  8'd8,  VL,    VL,    VL,
    8'd6,  8'd6,  8'd6,  VL,    VL,    VL,    VL,    8'd8,
    8'd8,  8'd1,  8'd1,  8'd2,  8'd2,  8'd2,  8'd2,  8'd2,
    8'd3,  8'd5,  8'd5,  8'd5,  8'd5,  8'd5,  8'd5,  8'd5,
    8'd5,  8'd6,  8'd6,  8'd6,  8'd6,  8'd8,  8'd8,  8'd8,
    8'd8,  8'd21, 8'd1,  8'd2,  8'd5,  8'd7,  8'd42, 8'd8,
    8'd9,  VA,    VN,    VN,    VA,    VA,    VA,    VL,
    VL,    VL,    VL,    VL,    VL,    VL,    VL,    VL,
    VL,    VL,    VL,    VL,    8'd2,  8'd5,  8'd8,  VL,
    VL,    VL,    VL,    VL,    VL,    VL,    VL,    8'd8
  };

  // mirrored registers
  logic       cfg_bcd;
  logic [7:0] cfg_target;
  logic [7:0] cfg_max;
  logic [7:0] cfg_extra;

  // walk state
  logic [10:0]  pos;
  logic [127:0] present;
  logic [7:0]   cur_field;
  logic [9:0]   left;
  logic [9:0]   acc_len;
  phase_t       phase;
  logic [1:0]   pfx_left;

  beat_tag_t tag_q[$];
  beat_tag_t want;
  beat_tag_t got;
  int        err_n;
  int        seen_n;

  task automatic clear_walk();
    pos       = '0;
    present   = '0;
    cur_field = '0;
    left      = '0;
    acc_len   = '0;
    phase     = PhId;
    pfx_left  = '0;
  endtask

  task automatic load_map_byte(input int base, input logic [7:0] b);
    int k;
    for (k = 0; k < 8; k++) begin
      if (b[7-k]) present[(base + k) & 127] = 1'b1;
    end
  endtask

  function automatic logic keeps_clear(input logic [7:0] f);
    logic hit;
    hit = 1'b0;
    if (f >= 8'd1 && f <= cfg_max) begin
      hit = (f == ClrRespCode) || (f == ClrTermId) || (f == ClrMerchId) || (f == ClrSecCtl) ||
            (cfg_extra != 8'd0 && f == cfg_extra);
    end
    return hit;
  endfunction

  task automatic open_field(input logic [7:0] f);
    logic [7:0] code;
    code      = FORMAT_TABLE[f];
    cur_field = f;
    acc_len   = '0;
    left      = '0;
    if (code < KindVarFlag) begin
      acc_len = 10'(code);
      left    = 10'(code);
      phase   = PhData;
    end else begin
      if (code == KindLln) pfx_left = 2'd1;
      else if (code == KindLll && !cfg_bcd) pfx_left = 2'd3;
      else pfx_left = 2'd2;
      phase = PhPrefix;
    end
  endtask

  // Predict the tag of one byte and advance the walk.
  task automatic tag_byte(input logic [7:0] b, input logic eom, output beat_tag_t t);
    logic [7:0] kind;
    logic [3:0] hi;
    logic [3:0] lo;
    logic       bad;
    logic       found;
    int         acc;
    int         len;
    int         k;
    int         off;
    int         f;
    t        = '0;
    t.data   = b;
    t.region = RegPast;
    t.eom    = eom;
    // position saturates below the buffer size, kept for completeness
    if (int'(pos) >= MessageBytes && phase != PhError) phase = PhPast;
    if (phase == PhSeek) begin
      phase = PhPast;
      found = 1'b0;
      for (f = int'(cur_field) + 1; f <= NumFields; f++) begin
        if (!found && present[(f - 1) & 127]) begin
          found = 1'b1;
          open_field(8'(f));
        end
      end
    end
    case (phase)
      PhId: begin
        t.region = RegId;
        t.offset = 10'(pos);
        t.clr    = 1'b1;
        t.sel    = (cfg_target == 8'd0);
        if (pos >= 11'd1) phase = PhPbmp;
      end
      PhPbmp: begin
        k        = (int'(pos) - 2) & 7;
        t.region = RegPbmp;
        t.offset = 10'(k);
        t.clr    = 1'b1;
        load_map_byte(8 * k, b);
        if (pos >= 11'd9) begin
          phase     = PhSeek;
          cur_field = '0;
        end
      end
      PhPrefix: begin
        kind    = FORMAT_TABLE[cur_field];
        acc     = int'(acc_len);
        bad     = 1'b0;
        t.field = cur_field;
        if (kind == KindLla || (kind == KindLll && !cfg_bcd)) begin
          if (b < AsciiZero || b > AsciiNine) bad = 1'b1;
          else acc = acc * 10 + int'(b - AsciiZero);
        end else begin
          hi = b[7:4];
          lo = b[3:0];
          if (hi > 4'd9) hi = 4'd0;
          if (lo > 4'd9) lo = 4'd0;
          // first byte of a two-byte length: pad nibble ignored
          if (pfx_left == 2'd2) acc = acc * 100 + int'(lo);
          else acc = acc * 100 + int'(hi) * 10 + int'(lo);
        end
        if (acc > 999) acc = 999;
        if (bad) begin
          t.region = RegError;
          phase    = PhError;
        end else begin
          t.region = RegPrefix;
          t.offset = left;
          t.clr    = (cur_field >= 8'd1 && cur_field <= cfg_max);
          left     = left + 10'd1;
          acc_len  = 10'(acc);
          if (pfx_left <= 2'd1) begin
            len      = acc;
            pfx_left = '0;
            if (kind == KindLln || kind == KindLlln) len = (acc + 1) / 2;
            acc_len = 10'(len);
            left    = 10'(len);
            phase   = (len == 0) ? PhSeek : PhData;
          end else begin
            pfx_left = pfx_left - 2'd1;
          end
        end
      end
      PhData: begin
        off      = (int'(acc_len) - int'(left)) & 1023;
        t.region = RegData;
        t.field  = cur_field;
        t.offset = 10'(off);
        t.clr    = keeps_clear(cur_field);
        t.sel    = (cfg_target != 8'd0 && cfg_target == cur_field);
        if (cur_field == 8'd1) load_map_byte(64 + 8 * (off & 7), b);
        if (left <= 10'd1) begin
          left  = '0;
          phase = PhSeek;
        end else begin
          left = left - 10'd1;
        end
      end
      PhError: begin
        t.region = RegError;
        t.field  = cur_field;
      end
      default: ;
    endcase
    if (eom) clear_walk();
    else if (pos < PosMax) pos = pos + 11'd1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_bcd    = 1'b1;
      cfg_target = 8'd0;
      cfg_max    = 8'd53;
      cfg_extra  = 8'd0;
      clear_walk();
      tag_q.delete();
      err_n  = 0;
      seen_n = 0;
      errors       <= 0;
      pending      <= 0;
      checked      <= 0;
      regions_seen <= '0;
    end else begin
      // results first: a beat accepted now belongs to an earlier input
      if (m_tvalid && m_tready) begin
        got = {m_tdata[7:0], m_tuser[2:0], m_tdata[15:8], m_tdata[25:16],
               m_tuser[3], m_tuser[4], m_tlast};
        seen_n++;
        if (got.region <= RegError) regions_seen[got.region] <= 1'b1;
        if (tag_q.size() == 0) begin
          err_n++;
          if (err_n <= 10) $display("unexpected beat %0d: nothing outstanding, got %h", seen_n, got);
        end else begin
          want = tag_q.pop_front();
          if (got.data != want.data || got.region != want.region || got.field != want.field ||
              got.offset != want.offset || got.clr != want.clr || got.sel != want.sel ||
              got.eom != want.eom) begin
            err_n++;
            if (err_n <= 10) begin
              $display("beat %0d: want byte %h reg %0d fld %0d off %0d clr %b sel %b eom %b",
                       seen_n, want.data, want.region, want.field, want.offset,
                       want.clr, want.sel, want.eom);
              $display("         got  byte %h reg %0d fld %0d off %0d clr %b sel %b eom %b",
                       got.data, got.region, got.field, got.offset, got.clr, got.sel, got.eom);
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        tag_byte(s_tdata, s_tlast, want);
        tag_q.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_index)
          CfgBcdLengths: cfg_bcd    = cfg_data[0];
          CfgTarget:     cfg_target = cfg_data;
          CfgMaxField:   cfg_max    = cfg_data;
          CfgExtraClear: cfg_extra  = cfg_data;
          default: ;
        endcase
      end
      errors  <= err_n;
      pending <= tag_q.size();
      checked <= seen_n;
    end
  end

endmodule

FILE: tb/tb_card_message_field_walker.sv
// Top of the card message field walker testbench: reset, register settings and message stimulus.
// Depends on cmfw_pkg, the walker and cmfw_tag_checker, which does all prediction and checking.
module tb_card_message_field_walker;
  import cmfw_pkg::*;

  // ~1k beats, each slowed by stalls on both sides: limit leaves >10x margin
  localparam int LimitCycles   = 400000;
  localparam int RandomItems   = 700;
  localparam int PhaseItems    = 90;
  localparam int LongDataBytes = 200;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic [7:0]  s_tdata   = '0;
  logic        s_tlast   = 1'b0;
  logic        m_tready  = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data  = '0;
  logic        s_tready;
  logic        m_tvalid;
  logic [31:0] m_tdata;   // [7:0] out_byte, [15:8] field_number, [25:16] offset_in_field
  logic [4:0]  m_tuser;   // [2:0] region, [3] is_clear, [4] is_selected
  logic        m_tlast;

  int          errors;
  int          pending;
  int          checked;
  logic [5:0]  regions_seen;

  always #5 clk = ~clk;

  card_message_field_walker uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cmfw_tag_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .checked(checked), .regions_seen(regions_seen)
  );

  // Watchdog: a hung handshake or a missing beat ends here.
  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("FAIL card_message_field_walker");
      $finish;
    end
  end

  // Output side: after each taken beat, m_tready may drop for a random stall. Quiet stretches come and go.
  logic rx_quiet = 1'b0;
  int   rx_hold  = 0;
  always @(posedge clk) begin : rx_side
    int n;
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold  <= 0;
    end else if (m_tready) begin
      if (m_tvalid) begin
        n = rx_quiet ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 39) == 0) rx_quiet <= ~rx_quiet;
        if (n != 0) begin
          m_tready <= 1'b0;
          rx_hold  <= n - 1;
        end
      end
    end else if (rx_hold == 0) begin
      m_tready <= 1'b1;
    end else begin
      rx_hold <= rx_hold - 1;
    end
  end

  // Message under construction: {last, byte} per entry.
  logic [8:0] msg_q[$];
  int         ascii_idx[$];   // positions of ASCII length digits, for corruption
  logic       tx_quiet  = 1'b0;
  logic       cur_bcd   = 1'b1;
  int         items_sent = 0;
  int         messages   = 0;
  int         settings   = 0;

  // Input side: one beat, after a random gap. Returns at the edge that takes it.
  task automatic send_beat(input logic [7:0] d, input logic l);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_message();
    int i;
    if ($urandom_range(0, 4) == 0) tx_quiet = ~tx_quiet;
    for (i = 0; i < msg_q.size(); i++) send_beat(msg_q[i][7:0], msg_q[i][8]);
    messages++;
  endtask

  // Hold the sender until every tagged beat is back and the output register is empty.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || m_tvalid) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Four back-to-back writes; the enable stays high across them and drops once.
  task automatic set_config(input logic bcd, input logic [7:0] tgt, input logic [7:0] mx,
                            input logic [7:0] extra);
    cfg_we    <= 1'b1;
    cfg_index <= CfgBcdLengths;
    cfg_data  <= {7'd0, bcd};
    @(posedge clk);
    cfg_index <= CfgTarget;
    cfg_data  <= tgt;
    @(posedge clk);
    cfg_index <= CfgMaxField;
    cfg_data  <= mx;
    @(posedge clk);
    cfg_index <= CfgExtraClear;
    cfg_data  <= extra;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_bcd = bcd;
    settings++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    msg_q.push_back({1'b0, b});
  endtask

  task automatic mark_last();
    msg_q[msg_q.size() - 1] = msg_q[msg_q.size() - 1] | 9'h100;
  endtask

  // Directed bytes, first byte in the top bits.
  task automatic load_bytes(input logic [103:0] bytes, input int n);
    int i;
    msg_q.delete();
    for (i = 0; i < n; i++) add_byte(bytes[8 * (n - 1 - i) +: 8]);
    mark_last();
  endtask

  // BCD digit; a zero sometimes goes out as an out-of-range nibble, which also reads as zero.
  function automatic logic [3:0] bcd_nib(input int d);
    logic [3:0] v;
    v = 4'(d);
    if (d == 0 && $urandom_range(0, 3) == 0) v = 4'($urandom_range(10, 15));
    return v;
  endfunction

  task automatic add_ascii(input int d);
    ascii_idx.push_back(msg_q.size());
    add_byte(AsciiZero + 8'(d));
  endtask

  // Length prefix plus data of a variable field, lengths mostly short.
  task automatic add_variable(input logic [7:0] code);
    int len;
    int n;
    int i;
    logic two_digit;
    two_digit = (code == KindLln || code == KindLla);
    if ($urandom_range(0, 7) == 0) len = two_digit ? $urandom_range(10, 99) : $urandom_range(10, 200);
    else len = $urandom_range(0, 9);
    n = len;
    if (code == KindLln) begin
      add_byte({bcd_nib(len / 10), bcd_nib(len % 10)});
      n = (len + 1) / 2;
    end else if (code == KindLla) begin
      add_ascii(len / 10);
      add_ascii(len % 10);
    end else if (code == KindLll && !cur_bcd) begin
      add_ascii(len / 100);
      add_ascii((len / 10) % 10);
      add_ascii(len % 10);
    end else begin
      // two BCD bytes: pad nibble, then three digits
      add_byte({4'($urandom_range(0, 15)), bcd_nib(len / 100)});
      add_byte({bcd_nib((len / 10) % 10), bcd_nib(len % 10)});
      if (code == KindLlln) n = (len + 1) / 2;
    end
    for (i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
  endtask

  // A message laid out as the field table says, with a sparse random bitmap.
  task automatic build_message();
    logic [128:1] want;
    logic [7:0]   code;
    logic [7:0]   mb;
    int f;
    int i;
    int k;
    want = '0;
    for (f = 2; f <= 64; f++) if ($urandom_range(0, 9) == 0) want[f] = 1'b1;
    // lean on the always-clear fields
    if ($urandom_range(0, 3) == 0) want[39] = 1'b1;
    if ($urandom_range(0, 3) == 0) want[41] = 1'b1;
    if ($urandom_range(0, 3) == 0) want[42] = 1'b1;
    if ($urandom_range(0, 3) == 0) want[53] = 1'b1;
    if ($urandom_range(0, 2) == 0) begin
      want[1] = 1'b1;
      for (f = 65; f <= 128; f++) if ($urandom_range(0, 11) == 0) want[f] = 1'b1;
    end
    if (chk.cfg_target >= 8'd1 && chk.cfg_target <= 8'd128 && $urandom_range(0, 1) == 0) begin
      want[chk.cfg_target] = 1'b1;
      if (chk.cfg_target > 8'd64) want[1] = 1'b1;
    end
    msg_q.delete();
    ascii_idx.delete();
    add_byte(8'($urandom_range(0, 255)));
    add_byte(8'($urandom_range(0, 255)));
    for (i = 0; i < 8; i++) begin
      for (k = 0; k < 8; k++) mb[7 - k] = want[8 * i + k + 1];
      add_byte(mb);
    end
    for (f = 1; f <= 128; f++) begin
      if (want[f]) begin
        if (f == 1) begin
          // secondary bitmap: fields 65..128
          for (i = 0; i < 8; i++) begin
            for (k = 0; k < 8; k++) mb[7 - k] = want[64 + 8 * i + k + 1];
            add_byte(mb);
          end
        end else begin
          code = FMT_ROM[f];
          if (code < KindVarFlag) begin
            for (i = 0; i < int'(code); i++) add_byte(8'($urandom_range(0, 255)));
          end else begin
            add_variable(code);
          end
        end
      end
    end
    // a few bytes past the last field
    repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] non_digit();
    logic [7:0] v;
    case ($urandom_range(0, 3))
      0: v = AsciiZero - 8'd1;
      1: v = AsciiNine + 8'd1;
      2: v = 8'($urandom_range(0, 47));
      default: v = 8'($urandom_range(58, 255));
    endcase
    return v;
  endfunction

  // Mostly well-formed messages; some cut short, some with a bad length digit, some noise.
  task automatic random_message();
    int pick;
    int keep;
    int n;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      msg_q.delete();
      n = $urandom_range(1, 30);
      repeat (n) add_byte(8'($urandom_range(0, 255)));
    end else begin
      build_message();
      if (pick < 5 && ascii_idx.size() != 0) begin
        keep = ascii_idx[$urandom_range(0, ascii_idx.size() - 1)];
        msg_q[keep] = {1'b0, non_digit()};
      end else if (pick < 7) begin
        keep = $urandom_range(1, msg_q.size());
        while (msg_q.size() > keep) void'(msg_q.pop_back());
      end
    end
    mark_last();
    send_message();
  endtask

  initial begin : stimulus
    int phase_n;
    int phase_start;
    int i;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed, at reset register values.
    // Field 2 with length byte FA: both nibbles out of range, so zero length, then past fields.
    load_bytes(104'hFF00_4000000000000000_FA5A, 12);
    send_message();
    // Field 34 ASCII length: '0', then a colon, then one byte in the error region.
    load_bytes(104'h00FF_0000000040000000_303A39, 13);
    send_message();
    wait_idle();

    // Random phases: extreme settings first, then random ones.
    items_sent = 0;
    for (phase_n = 0; items_sent < RandomItems; phase_n++) begin
      case (phase_n)
        0: set_config(1'b1, 8'd0, 8'd53, 8'd0);
        1: set_config(1'b0, 8'd128, 8'd128, 8'd128);
        2: set_config(1'b1, 8'd1, 8'd0, 8'd0);
        3: set_config(1'b0, 8'd255, 8'd255, 8'd255);
        4: set_config(1'b1, 8'd41, 8'd128, 8'd2);
        default: set_config(1'($urandom_range(0, 1)), 8'($urandom_range(0, 128)),
                            8'($urandom_range(0, 128)), 8'($urandom_range(0, 128)));
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) random_message();
      wait_idle();
    end

    // Longest length: field 48 with ASCII length 999, message ends partway into the data.
    set_config(1'b0, 8'd48, 8'd128, 8'd48);
    msg_q.delete();
    add_byte(8'h12);
    add_byte(8'h34);
    for (i = 0; i < 8; i++) add_byte((i == 5) ? 8'h01 : 8'h00);
    for (i = 0; i < 3; i++) add_byte(AsciiNine);
    for (i = 0; i < LongDataBytes; i++) add_byte(8'($urandom_range(0, 255)));
    mark_last();
    send_message();
    wait_idle();

    $display("%0d messages, %0d beats checked, %0d register settings", messages, checked,
             settings);
    $display("regions reported (error..id): %b", regions_seen);
    if (errors == 0) $display("PASS card_message_field_walker");
    else $display("FAIL card_message_field_walker");
    $finish;
  end

endmodule
